[rtl/bts_pkg.sv]
// Shared types, constants and helpers for the bilinear texture sampler.
// Depends on nothing; every other file of the block imports it.
package bts_pkg;

	localparam int MAX_SIDE_DEF     = 256;
	localparam int STORE_TEXELS_DEF = 65536;

	localparam logic [2:0] REG_TEX_WIDTH  = 3'd0;
	localparam logic [2:0] REG_TEX_HEIGHT = 3'd1;
	localparam logic [2:0] REG_WRAP_U     = 3'd2;
	localparam logic [2:0] REG_WRAP_V     = 3'd3;
	localparam logic [2:0] REG_FILTER     = 3'd4;
	localparam logic [2:0] REG_BOUND      = 3'd5;

	localparam logic [1:0] WRAP_CLAMP  = 2'd0;
	localparam logic [1:0] WRAP_REPEAT = 2'd1;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	typedef struct packed {
		logic               operation;
		logic [15:0]        texel_address;
		logic [31:0]        texel_value;
		logic signed [31:0] coord_u;
		logic signed [31:0] coord_v;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} out_item_t;

	typedef struct packed {
		logic [8:0] tex_width;
		logic [8:0] tex_height;
		logic [1:0] wrap_u_mode;
		logic [1:0] wrap_v_mode;
		logic       filter_linear;
		logic       texture_bound;
	} cfg_t;

	// Magnitude with the wrap mode applied; result fits in 32 bits.
	function automatic logic [31:0] wrap_mag(input logic [31:0] v, input logic [1:0] mode);
		logic [31:0] m;
		m = v[31] ? (32'd0 - v) : v;
		case (mode)
			WRAP_CLAMP:  wrap_mag = (m > 32'd65536) ? 32'd65536 : m;
			WRAP_REPEAT: wrap_mag = {16'd0, m[15:0]};
			default:     wrap_mag = m;
		endcase
	endfunction

endpackage

[rtl/bts_front.sv]
// Front end: effective sizes, wrap, scale and texel coordinate selection.
// Depends on bts_pkg. Produces one classified command per accepted item.
module bts_front #(
	parameter int MAX_SIDE = bts_pkg::MAX_SIDE_DEF,
	parameter int SW = $clog2(MAX_SIDE + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bts_pkg::cfg_t         cfg,
	input  logic                  in_valid,
	input  bts_pkg::in_item_t     in_item,
	output logic                  in_ready,
	output logic                  cmd_valid,
	output logic                  cmd_write,
	output logic                  cmd_white,
	output logic                  cmd_linear,
	output logic [15:0]           cmd_waddr,
	output logic [31:0]           cmd_wdata,
	output logic [SW-1:0]         cmd_x0,
	output logic [SW-1:0]         cmd_x1,
	output logic [SW-1:0]         cmd_y0,
	output logic [SW-1:0]         cmd_y1,
	output logic [SW-1:0]         cmd_w,
	output logic [16:0]           cmd_fx,
	output logic [16:0]           cmd_fy,
	input  logic                  cmd_ready
);
	import bts_pkg::*;

	localparam int PW = 32 + SW + 1;

	logic [SW-1:0] w_eff, h_eff;
	logic [SW-1:0] w_c, h_c;
	logic [SW:0]   mw, mh;
	logic [31:0]   mu, mv;
	logic [PW-1:0] pu, pv;
	logic          s1_valid_q, s2_valid_q, adv1;
	in_item_t      item_s1;
	logic [31:0]   mu_s1, mv_s1;
	logic [PW-1:0] pu_s2, pv_s2;
	logic          op_s2;
	logic [15:0]   a_s2;
	logic [31:0]   d_s2;
	logic [PW-1:0] xr, yr, xi, yi;

	// Clamp the configured sizes into 1..MAX_SIDE.
	assign w_c = ({23'd0, cfg.tex_width} > 32'(MAX_SIDE)) ? SW'(MAX_SIDE)
		: SW'(cfg.tex_width);
	assign h_c = ({23'd0, cfg.tex_height} > 32'(MAX_SIDE)) ? SW'(MAX_SIDE)
		: SW'(cfg.tex_height);
	assign w_eff = (cfg.tex_width == 9'd0) ? SW'(1) : w_c;
	assign h_eff = (cfg.tex_height == 9'd0) ? SW'(1) : h_c;
	assign mw = {w_eff, 1'b0} - (SW+1)'(1);
	assign mh = {h_eff, 1'b0} - (SW+1)'(1);

	// Two-stage pipe: wrap then multiply; stalls only when the back end holds cmd_ready low.
	assign adv1 = !s2_valid_q || cmd_ready;
	assign in_ready = !s1_valid_q || adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (adv1) s2_valid_q <= s1_valid_q;
			if (in_ready) s1_valid_q <= in_valid;
		end
	end

	// Stage 1 payload: magnitudes after wrap.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
			mu_s1 <= wrap_mag(in_item.coord_u, cfg.wrap_u_mode);
			mv_s1 <= wrap_mag(in_item.coord_v, cfg.wrap_v_mode);
		end
	end

	assign mu = mu_s1;
	assign mv = mv_s1;
	assign pu = PW'(mu) * PW'(mw);
	assign pv = PW'(mv) * PW'(mh);

	// Stage 2 payload: scaled positions with 17 fraction bits.
	always_ff @(posedge clk) begin
		if (adv1 && s1_valid_q) begin
			pu_s2 <= pu;
			pv_s2 <= pv;
			op_s2 <= item_s1.operation;
			a_s2  <= item_s1.texel_address;
			d_s2  <= item_s1.texel_value;
		end
	end

	// Texel selection from the scaled positions.
	assign xr = (pu_s2 + PW'(65536)) >> 17;
	assign yr = (pv_s2 + PW'(65536)) >> 17;
	assign xi = pu_s2 >> 17;
	assign yi = pv_s2 >> 17;

	always_comb begin
		logic [PW-1:0] xs, ys;
		logic [SW-1:0] wm1, hm1;
		wm1 = w_eff - SW'(1);
		hm1 = h_eff - SW'(1);
		xs = cfg.filter_linear ? xi : xr;
		ys = cfg.filter_linear ? yi : yr;
		cmd_x0 = (xs > PW'(wm1)) ? wm1 : SW'(xs);
		cmd_y0 = (ys > PW'(hm1)) ? hm1 : SW'(ys);
		cmd_x1 = (cmd_x0 < wm1) ? cmd_x0 + SW'(1) : wm1;
		cmd_y1 = (cmd_y0 < hm1) ? cmd_y0 + SW'(1) : hm1;
	end

	assign cmd_valid  = s2_valid_q;
	assign cmd_write  = (op_s2 == OP_WRITE);
	assign cmd_white  = !cfg.texture_bound;
	assign cmd_linear = cfg.filter_linear;
	assign cmd_waddr  = a_s2;
	assign cmd_wdata  = d_s2;
	assign cmd_w      = w_eff;
	assign cmd_fx     = pu_s2[16:0];
	assign cmd_fy     = pv_s2[16:0];

endmodule

[rtl/bts_back.sv]
// Back end: texel store, four-read fetch sequencer and bilinear blend.
// Depends on bts_pkg. Consumes commands, pushes results to the output register.
module bts_back #(
	parameter int MAX_SIDE = bts_pkg::MAX_SIDE_DEF,
	parameter int STORE_TEXELS = bts_pkg::STORE_TEXELS_DEF,
	parameter int SW = $clog2(MAX_SIDE + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  logic              cmd_write,
	input  logic              cmd_white,
	input  logic              cmd_linear,
	input  logic [15:0]       cmd_waddr,
	input  logic [31:0]       cmd_wdata,
	input  logic [SW-1:0]     cmd_x0,
	input  logic [SW-1:0]     cmd_x1,
	input  logic [SW-1:0]     cmd_y0,
	input  logic [SW-1:0]     cmd_y1,
	input  logic [SW-1:0]     cmd_w,
	input  logic [16:0]       cmd_fx,
	input  logic [16:0]       cmd_fy,
	output logic              cmd_ready,
	output logic              res_valid,
	output bts_pkg::out_item_t res_item,
	input  logic              res_ready
);
	import bts_pkg::*;

	localparam int AW = (STORE_TEXELS > 1) ? $clog2(STORE_TEXELS) : 1;
	localparam int LW = 2 * SW + 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_READ  = 3'd1;
	localparam logic [2:0] ST_ACC   = 3'd2;
	localparam logic [2:0] ST_ROUND = 3'd3;

	logic [31:0]   mem [STORE_TEXELS];
	logic [31:0]   rdata_q;
	logic [2:0]    state_q;
	logic [2:0]    cnt_q;
	logic          rd_pend_q;
	logic [SW-1:0] x0_q, x1_q, y0_q, y1_q, w_q;
	logic [16:0]   fx_q, fy_q;
	logic          lin_q;
	logic [35:0]   wt_q;
	logic [35:0]   wgt;
	logic [43:0]   acc_q [4];
	logic [SW-1:0] rx, ry;
	logic [LW-1:0] lin_addr;
	logic [AW-1:0] raddr;
	logic          rd_en, out_busy_q, start;
	logic          white_take, round_done, res_load;
	out_item_t     out_q;

	assign start = (state_q == ST_IDLE) && cmd_valid && !cmd_write && !cmd_white;
	// A write retires at once, a sample moves into the sequencer, and a white
	// result retires when the output slot is free or its result is being popped.
	assign cmd_ready = (state_q == ST_IDLE)
		&& (cmd_write || start || !out_busy_q || res_ready);
	assign white_take = (state_q == ST_IDLE) && cmd_valid && !cmd_write && cmd_white
		&& cmd_ready;
	assign round_done = (state_q == ST_ROUND) && (!out_busy_q || res_ready);
	assign res_load = white_take || round_done;

	// Texel address of read number cnt: 0 (x0,y0), 1 (x1,y0), 2 (x0,y1), 3 (x1,y1).
	always_comb begin
		rx = cnt_q[0] ? x1_q : x0_q;
		ry = cnt_q[1] ? y1_q : y0_q;
		lin_addr = LW'(ry) * LW'(w_q) + LW'(rx);
		raddr = AW'(lin_addr);
	end
	assign rd_en = (state_q == ST_READ);

	// Single-port store: writes from write commands, one read per cycle.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid && cmd_write) begin
			if (32'(cmd_waddr) < 32'(STORE_TEXELS)) mem[AW'(cmd_waddr)] <= cmd_wdata;
		end else if (rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	// Weight of the texel being read, registered next to the read data.
	always_comb begin
		logic [17:0] ax, ay;
		ax = cnt_q[0] ? {1'b0, fx_q} : (18'h20000 - {1'b0, fx_q});
		ay = cnt_q[1] ? {1'b0, fy_q} : (18'h20000 - {1'b0, fy_q});
		if (!lin_q) begin
			ax = 18'h20000;
			ay = 18'h20000;
		end
		wgt = 36'(ax) * 36'(ay);
	end

	// Sequencer: read four texels (one for nearest), accumulate, round.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= 3'd0;
			rd_pend_q <= 1'b0;
			out_busy_q <= 1'b0;
		end else begin
			out_busy_q <= res_load || (out_busy_q && !res_ready);
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_READ;
						cnt_q <= 3'd0;
					end
				end
				ST_READ: begin
					rd_pend_q <= 1'b1;
					if (!lin_q || cnt_q == 3'd3) state_q <= ST_ACC;
					cnt_q <= cnt_q + 3'd1;
				end
				ST_ACC: begin
					rd_pend_q <= 1'b0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					if (round_done) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Capture the command and accumulate weighted channels in units of 2^-34.
	always_ff @(posedge clk) begin
		if (start) begin
			x0_q <= cmd_x0; x1_q <= cmd_x1;
			y0_q <= cmd_y0; y1_q <= cmd_y1;
			w_q <= cmd_w; fx_q <= cmd_fx; fy_q <= cmd_fy;
			lin_q <= cmd_linear;
			for (int c = 0; c < 4; c++) acc_q[c] <= '0;
		end else if (rd_pend_q) begin
			for (int c = 0; c < 4; c++)
				acc_q[c] <= acc_q[c] + 44'(rdata_q[8*c +: 8]) * 44'(wt_q);
		end
		if (rd_en) wt_q <= wgt;
	end

	// Output register: white for unbound samples, rounded blend otherwise.
	always_ff @(posedge clk) begin
		if (white_take)
			out_q <= '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
		else if (round_done) begin
			out_q.red   <= 8'((acc_q[0] + 44'h2_0000_0000) >> 34);
			out_q.green <= 8'((acc_q[1] + 44'h2_0000_0000) >> 34);
			out_q.blue  <= 8'((acc_q[2] + 44'h2_0000_0000) >> 34);
			out_q.alpha <= 8'((acc_q[3] + 44'h2_0000_0000) >> 34);
		end
	end

	assign res_valid = out_busy_q;
	assign res_item = out_q;

endmodule

[rtl/bilinear_texture_sampler_core.sv]
// Top level of the bilinear texture sampler: config registers, front, back.
// Depends on bts_pkg, bts_front and bts_back.
//
// Usage: items enter through push/full (in_item); results leave through
// empty/pop (out_item), one per sample item, none per write item.
// Registers are written on the cfg channel (cfg_valid/cfg_ready, cfg_index,
// cfg_data); the user must write them only while the block is idle, as the
// block itself does not enforce it. An item passes the wrap and multiply
// stages of the front pipe; the back end then reads, accumulates and rounds a
// sample into the output register, or loads white into it when unbound.
// The back end takes a new command only when idle: a write retires at once;
// a sample is paced by the single-port texel store, which serves one of the
// four neighbor reads per cycle, plus the accumulate and round steps.
// The front pipe keeps accepting only until its stages fill while the back
// end works or a result waits; when pop stays low, the output register holds
// and the stall backs up through the back end into the front pipe and full.
// Reset clears control state and the registers to width 1, height 1,
// clamp, nearest, unbound; the texel store is undefined until written.
module bilinear_texture_sampler_core #(
	parameter int MAX_SIDE = bts_pkg::MAX_SIDE_DEF,
	parameter int STORE_TEXELS = bts_pkg::STORE_TEXELS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  bts_pkg::in_item_t  in_item,
	output logic               empty,
	input  logic               pop,
	output bts_pkg::out_item_t out_item,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [8:0]         cfg_data
);
	import bts_pkg::*;

	localparam int SW = $clog2(MAX_SIDE + 1);

	cfg_t          cfg_q;
	logic          in_ready, cmd_valid, cmd_ready, cmd_write, cmd_white, cmd_linear;
	logic [15:0]   cmd_waddr;
	logic [31:0]   cmd_wdata;
	logic [SW-1:0] cmd_x0, cmd_x1, cmd_y0, cmd_y1, cmd_w;
	logic [16:0]   cmd_fx, cmd_fy;
	logic          res_valid;

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{9'd1, 9'd1, WRAP_CLAMP, WRAP_CLAMP, 1'b0, 1'b0};
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TEX_WIDTH:  cfg_q.tex_width <= cfg_data;
				REG_TEX_HEIGHT: cfg_q.tex_height <= cfg_data;
				REG_WRAP_U:     cfg_q.wrap_u_mode <= cfg_data[1:0];
				REG_WRAP_V:     cfg_q.wrap_v_mode <= cfg_data[1:0];
				REG_FILTER:     cfg_q.filter_linear <= cfg_data[0];
				REG_BOUND:      cfg_q.texture_bound <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign full = !in_ready;
	assign empty = !res_valid;

	bts_front #(.MAX_SIDE(MAX_SIDE), .SW(SW)) u_front (
		.clk, .arst_n, .cfg(cfg_q), .in_valid(push), .in_item, .in_ready,
		.cmd_valid, .cmd_write, .cmd_white, .cmd_linear, .cmd_waddr, .cmd_wdata,
		.cmd_x0, .cmd_x1, .cmd_y0, .cmd_y1, .cmd_w, .cmd_fx, .cmd_fy, .cmd_ready
	);

	bts_back #(.MAX_SIDE(MAX_SIDE), .STORE_TEXELS(STORE_TEXELS), .SW(SW)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_write, .cmd_white, .cmd_linear, .cmd_waddr,
		.cmd_wdata, .cmd_x0, .cmd_x1, .cmd_y0, .cmd_y1, .cmd_w, .cmd_fx, .cmd_fy,
		.cmd_ready, .res_valid, .res_item(out_item), .res_ready(pop)
	);

`ifndef ASSERT_OFF
	// A waiting result holds until it is popped.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_item)))
		else $error("result changed while waiting");
	// A white result is taken only when the output slot is free or leaving.
	a_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_ready && cmd_valid && !cmd_write && cmd_white) |-> (empty || pop))
		else $error("result overwritten");
`endif

endmodule

[dv/tb_top.sv]
// Testbench for the bilinear texture sampler core: a queue-fed driver, a result
// monitor and a texel-level predictor of nearest and bilinear sampling.
// Depends on bts_pkg and bilinear_texture_sampler_core.
module tb_top;
	import bts_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       push;
	logic       full;
	in_item_t   in_item;
	logic       empty;
	logic       pop;
	out_item_t  out_item;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_index;
	logic [8:0] cfg_data;

	bilinear_texture_sampler_core dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .in_item(in_item),
		.empty(empty), .pop(pop), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Items waiting to be offered, and samples waiting for their result.
	in_item_t  pending_items[$];
	out_item_t expected_texels[$];

	// Predictor copy of the texture and of the registers.
	logic [31:0] texel_mem [0:65535];
	cfg_t        cur_cfg;

	int  errors;
	bit  item_taken;
	bit  sender_idles;
	bit  receiver_stalls;
	bit  long_hold_req;
	int  hold_left;
	int  burst_left;
	int  gap_left;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint unsigned side_of(input logic [8:0] s);
		if (s == 9'd0) return 1;
		if (s > 9'd256) return 256;
		return s;
	endfunction

	// Scaled position with 17 fraction bits after the wrap mode.
	function automatic longint unsigned place_coord(input logic [31:0] raw,
			input logic [1:0] mode, input longint unsigned side);
		logic [31:0] mag;
		mag = raw[31] ? (32'd0 - raw) : raw;
		if (mode == WRAP_CLAMP) begin
			if (mag > 32'd65536) mag = 32'd65536;
		end else if (mode == WRAP_REPEAT) begin
			mag = {16'd0, mag[15:0]};
		end
		return longint'(mag) * (2 * side - 1);
	endfunction

	function automatic logic [31:0] texel_at(input longint unsigned x,
			input longint unsigned y, input longint unsigned w);
		return texel_mem[(y * w + x) % 65536];
	endfunction

	function automatic out_item_t sample_texture(input in_item_t it);
		longint unsigned w, h, pu, pv, xi, yi, x0, y0, x1, y1, fx, fy, one, acc;
		longint unsigned wt [4];
		logic [31:0] t [4];
		logic [7:0] ch [4];
		out_item_t r;
		one = 64'd1 << 17;
		if (!cur_cfg.texture_bound) return '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
		w = side_of(cur_cfg.tex_width);
		h = side_of(cur_cfg.tex_height);
		pu = place_coord(it.coord_u, cur_cfg.wrap_u_mode, w);
		pv = place_coord(it.coord_v, cur_cfg.wrap_v_mode, h);
		if (!cur_cfg.filter_linear) begin
			xi = (pu + 65536) >> 17;
			yi = (pv + 65536) >> 17;
			if (xi > w - 1) xi = w - 1;
			if (yi > h - 1) yi = h - 1;
			t[0] = texel_at(xi, yi, w);
			return '{t[0][7:0], t[0][15:8], t[0][23:16], t[0][31:24]};
		end
		xi = pu >> 17;
		yi = pv >> 17;
		fx = pu & (one - 1);
		fy = pv & (one - 1);
		x0 = (xi > w - 1) ? w - 1 : xi;
		y0 = (yi > h - 1) ? h - 1 : yi;
		x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
		y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
		t[0] = texel_at(x0, y0, w);
		t[1] = texel_at(x1, y0, w);
		t[2] = texel_at(x0, y1, w);
		t[3] = texel_at(x1, y1, w);
		wt[0] = (one - fx) * (one - fy);
		wt[1] = fx * (one - fy);
		wt[2] = (one - fx) * fy;
		wt[3] = fx * fy;
		for (int c = 0; c < 4; c++) begin
			acc = 0;
			for (int k = 0; k < 4; k++)
				acc += longint'((t[k] >> (8 * c)) & 32'hFF) * wt[k];
			acc = (acc + (64'd1 << 33)) >> 34;
			ch[c] = (acc > 255) ? 8'hFF : acc[7:0];
		end
		r.red = ch[0];
		r.green = ch[1];
		r.blue = ch[2];
		r.alpha = ch[3];
		return r;
	endfunction

	// Monitor: input beats feed the predictor, result beats are checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TEX_WIDTH:  cur_cfg.tex_width = cfg_data;
					REG_TEX_HEIGHT: cur_cfg.tex_height = cfg_data;
					REG_WRAP_U:     cur_cfg.wrap_u_mode = cfg_data[1:0];
					REG_WRAP_V:     cur_cfg.wrap_v_mode = cfg_data[1:0];
					REG_FILTER:     cur_cfg.filter_linear = cfg_data[0];
					REG_BOUND:      cur_cfg.texture_bound = cfg_data[0];
					default: ;
				endcase
			end
			if (push && !full) begin
				item_taken = 1'b1;
				if (in_item.operation == OP_WRITE)
					texel_mem[in_item.texel_address] = in_item.texel_value;
				else
					expected_texels.push_back(sample_texture(in_item));
			end
			if (pop && !empty) begin
				if (expected_texels.size() == 0) begin
					errors++;
					$display("%0t: unexpected result %h", $realtime, out_item);
				end else begin
					out_item_t e;
					e = expected_texels.pop_front();
					if (e.red !== out_item.red)
						$display("%0t: red expected %h actual %h", $realtime, e.red,
							out_item.red);
					if (e.green !== out_item.green)
						$display("%0t: green expected %h actual %h", $realtime, e.green,
							out_item.green);
					if (e.blue !== out_item.blue)
						$display("%0t: blue expected %h actual %h", $realtime, e.blue,
							out_item.blue);
					if (e.alpha !== out_item.alpha)
						$display("%0t: alpha expected %h actual %h", $realtime, e.alpha,
							out_item.alpha);
					if (e !== out_item) errors++;
				end
			end
		end
	end

	// Driver: offers queued items, in bursts separated by random gaps when sender_idles is set.
	always @(negedge clk) begin
		if (item_taken) begin
			void'(pending_items.pop_front());
			item_taken = 1'b0;
		end
		if (gap_left > 0) begin
			gap_left--;
			push <= 1'b0;
		end else if (pending_items.size() != 0) begin
			push <= 1'b1;
			in_item <= pending_items[0];
			if (sender_idles) begin
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 12);
					gap_left = $urandom_range(0, 6);
				end
			end
		end else begin
			push <= 1'b0;
		end
	end

	// Receiver: stalls on its own pattern, and once holds off for a long stretch.
	always @(negedge clk) begin
		if (long_hold_req) begin
			hold_left = 400;
			long_hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			pop <= 1'b0;
		end else if (receiver_stalls) begin
			pop <= ($urandom_range(0, 9) < 6);
		end else begin
			pop <= 1'b1;
		end
	end

	task automatic queue_write(input logic [15:0] addr, input logic [31:0] val);
		in_item_t it;
		it.operation = OP_WRITE;
		it.texel_address = addr;
		it.texel_value = val;
		it.coord_u = $urandom;
		it.coord_v = $urandom;
		pending_items.push_back(it);
	endtask

	task automatic queue_sample(input logic [31:0] u, input logic [31:0] v);
		in_item_t it;
		it.operation = OP_SAMPLE;
		it.texel_address = 16'($urandom);
		it.texel_value = $urandom;
		it.coord_u = u;
		it.coord_v = v;
		pending_items.push_back(it);
	endtask

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 4))
			0: return $urandom;
			1: return $urandom_range(0, 32'h0001_0000);
			2: return 32'd0 - $urandom_range(0, 32'h0001_0000);
			3: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
			default: return 32'h0001_0000 + $urandom_range(0, 32) - 16;
		endcase
	endfunction

	task automatic write_reg(input logic [2:0] idx, input logic [8:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Waits until every queued item is in and every result is out, then
	// lets the write path drain.
	task automatic drain();
		while (pending_items.size() != 0 || expected_texels.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	// One setting: program every register, load the texture, then sample.
	task automatic run_setting(input logic [8:0] w, input logic [8:0] h,
			input logic [1:0] wu, input logic [1:0] wv, input logic lin,
			input logic bound, input int samples);
		longint unsigned texels;
		drain();
		write_reg(REG_TEX_WIDTH, w);
		write_reg(REG_TEX_HEIGHT, h);
		write_reg(REG_WRAP_U, {7'd0, wu});
		write_reg(REG_WRAP_V, {7'd0, wv});
		write_reg(REG_FILTER, {8'd0, lin});
		write_reg(REG_BOUND, {8'd0, bound});
		@(negedge clk);
		cfg_valid <= 1'b0;
		sender_idles = ($urandom_range(0, 3) != 0);
		receiver_stalls = ($urandom_range(0, 3) != 0);
		texels = side_of(w) * side_of(h);
		for (longint unsigned a = 0; a < texels; a++)
			queue_write(a[15:0], $urandom);
		for (int n = 0; n < samples; n++) begin
			if ($urandom_range(0, 4) == 0)
				queue_write(16'($urandom), $urandom);
			queue_sample(pick_coord(), pick_coord());
		end
	endtask

	initial begin
		logic [31:0] edge_coords [8];
		errors = 0;
		item_taken = 1'b0;
		sender_idles = 1'b0;
		receiver_stalls = 1'b0;
		long_hold_req = 1'b0;
		hold_left = 0;
		burst_left = 0;
		gap_left = 0;
		push = 1'b0;
		pop = 1'b0;
		in_item = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_TEX_WIDTH;
		cfg_data = '0;
		cur_cfg = '{9'd1, 9'd1, WRAP_CLAMP, WRAP_CLAMP, 1'b0, 1'b0};
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// Unbound texture: samples give white whatever the coordinates.
		queue_sample(32'h0, 32'h0);
		queue_sample(32'h8000_0000, 32'h7FFF_FFFF);
		queue_write(16'hFFFF, 32'hFFFF_FFFF);
		queue_write(16'h0000, 32'h0000_0000);

		// Coordinate extremes under nearest and bilinear filtering.
		edge_coords = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
			32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000, 32'h0001_8000};
		for (int f = 0; f < 2; f++) begin
			run_setting(9'd4, 9'd3, WRAP_CLAMP, WRAP_REPEAT, f[0], 1'b1, 0);
			for (int k = 0; k < 8; k++)
				queue_sample(edge_coords[k], edge_coords[7 - k]);
		end
		// No wrap and wrap code three push the near texel past the edge.
		run_setting(9'd3, 9'd2, 2'd2, 2'd3, 1'b1, 1'b1, 0);
		for (int k = 0; k < 4; k++)
			queue_sample(edge_coords[k], edge_coords[k + 4]);

		// Size extremes, including zero and sizes above the maximum.
		run_setting(9'd0, 9'd5, WRAP_REPEAT, WRAP_CLAMP, 1'b1, 1'b1, 60);
		run_setting(9'd300, 9'd2, WRAP_REPEAT, 2'd2, 1'b1, 1'b1, 20);
		run_setting(9'd1, 9'd511, 2'd3, WRAP_CLAMP, 1'b0, 1'b1, 20);

		// A long receiver hold while the sender keeps offering samples.
		run_setting(9'd5, 9'd4, WRAP_REPEAT, WRAP_CLAMP, 1'b1, 1'b1, 150);
		@(negedge clk);
		long_hold_req = 1'b1;

		// Random settings with small textures.
		for (int p = 0; p < 5; p++)
			run_setting(9'($urandom_range(1, 9)), 9'($urandom_range(1, 9)),
				2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
				1'($urandom_range(0, 1)), ($urandom_range(0, 6) != 0), 40);
		run_setting(9'd2, 9'd2, WRAP_CLAMP, WRAP_CLAMP, 1'b0, 1'b0, 40);

		drain();
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
